[hw/rtl/merm_pkg.sv]
package merm_pkg;

  localparam int unsigned RULES = 16;
  localparam int unsigned IDX_W = $clog2(RULES);
  localparam int unsigned CNT_W = $clog2(RULES + 1);

  typedef struct packed {
    logic [23:0] mask;
    logic [23:0] match;
    logic [1:0]  len;
  } rule_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } seq_state_e;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_EVENT = 1'b1
  } cmd_e;

endpackage

[hw/rtl/merm_rule_table.sv]
module merm_rule_table
  import merm_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  rule_t            wdata_i,
  input  logic [IDX_W-1:0] raddr_i,
  output rule_t            rdata_o
);

  rule_t mem [RULES];
  rule_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Synchronous read: the data for raddr_i is registered into rdata_q.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/midi_event_rule_matcher_unit.sv]
// MIDI event rule matcher. A request is taken at a rising edge where start
// is high and busy is low. A load request (cmd 0) writes one rule entry in
// that cycle and leaves busy low. An event request (cmd 1) with a length of
// one to three bytes and a nonzero rule count raises busy while the rules
// are scanned one entry per cycle through the synchronous rule memory and a
// single mask-and-compare unit; events of any other length, or with no rules
// in use, are dropped without results. An event holds busy high through the
// scan and a final flush state, and no new request is taken until busy falls
// again, since start is ignored while busy is high. Each matching rule
// produces one result, in ascending rule order, held on the result ports for
// exactly one cycle and marked by out_strobe_o; the receiver cannot stall, so
// it must take every strobed result. The final result of an event carries
// last_match_o and appears in the first cycle after busy falls. Results trail
// the scan by one hit, because a hit is only known to be the last once the
// rest of the table has been checked.
// Rule entries hold no reset value, so only entries that have been loaded
// may be brought into use through the rules_in_use register (cfg_we_i and
// cfg_wdata_i), which must be written only while the block is idle.
module midi_event_rule_matcher_unit
  import merm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       cmd_i,
  input  logic [3:0] rule_slot_i,
  input  logic [1:0] rule_length_i,
  input  logic [7:0] mask_first_i,
  input  logic [7:0] mask_second_i,
  input  logic [7:0] mask_third_i,
  input  logic [7:0] byte_first_i,
  input  logic [7:0] byte_second_i,
  input  logic [7:0] byte_third_i,
  input  logic [2:0] event_length_i,
  output logic       out_strobe_o,
  output logic [3:0] rule_number_o,
  output logic       last_match_o,
  output logic [7:0] out_status_o,
  output logic [7:0] out_data_one_o,
  output logic [7:0] out_data_two_o,
  output logic [1:0] out_length_o
);

  // Configuration register, saturated to the table depth when used.
  logic [4:0]       rules_in_use_q;
  logic [CNT_W-1:0] count_eff;

  // Sequencer and scan state.
  seq_state_e       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             issued_all_q, issued_all_d;
  logic             rdv_q, rdv_d;
  logic             rdlast_q, rdlast_d;
  logic [IDX_W-1:0] rdi_q, rdi_d;
  logic             pend_q, pend_d;
  logic [IDX_W-1:0] pend_idx_q, pend_idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Latched event, already padded with zero bytes.
  logic [23:0]      ev_bytes_q, ev_bytes_d;
  logic [1:0]       ev_len_q, ev_len_d;

  // Result registers.
  logic             strobe_q, strobe_d;
  logic [3:0]       num_q, num_d;
  logic             last_q, last_d;
  logic [23:0]      obytes_q, obytes_d;
  logic [1:0]       olen_q, olen_d;

  logic             accept;
  logic             len_ok;
  logic [23:0]      pad_bytes;
  logic [23:0]      lane_mask;
  logic             hit;
  logic             mem_we;
  rule_t            wr_rule;
  rule_t            rd_rule;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign len_ok = (event_length_i >= 3'd1) && (event_length_i <= 3'd3);

  assign count_eff = ({27'd0, rules_in_use_q} > 32'(RULES))
                     ? CNT_W'(RULES) : CNT_W'(rules_in_use_q);

  always_comb begin
    pad_bytes = {byte_third_i, byte_second_i, byte_first_i};
    if (event_length_i < 3'd3) begin
      pad_bytes[23:16] = 8'h00;
    end
    if (event_length_i < 3'd2) begin
      pad_bytes[15:8] = 8'h00;
    end
  end

  // Loads are written in the cycle they are accepted.
  assign mem_we  = accept && (cmd_i == CMD_LOAD) &&
                   ({1'b0, rule_slot_i} < 5'(RULES));
  assign wr_rule = '{mask:  {mask_third_i, mask_second_i, mask_first_i},
                     match: {byte_third_i, byte_second_i, byte_first_i},
                     len:   rule_length_i};

  merm_rule_table u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (rule_slot_i[IDX_W-1:0]),
    .wdata_i (wr_rule),
    .raddr_i (idx_q),
    .rdata_o (rd_rule)
  );

  // Shared compare unit: only bytes that are present take part.
  always_comb begin
    lane_mask = 24'h0000ff;
    if (ev_len_q >= 2'd2) begin
      lane_mask[15:8] = 8'hff;
    end
    if (ev_len_q == 2'd3) begin
      lane_mask[23:16] = 8'hff;
    end
    hit = ((rd_rule.len == 2'd0) || (rd_rule.len == ev_len_q)) &&
          ((((ev_bytes_q & rd_rule.mask) ^ rd_rule.match) & lane_mask) == 24'h0);
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    issued_all_d = issued_all_q;
    rdv_d        = 1'b0;
    rdlast_d     = 1'b0;
    rdi_d        = idx_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    cnt_d        = cnt_q;
    ev_bytes_d   = ev_bytes_q;
    ev_len_d     = ev_len_q;
    strobe_d     = 1'b0;
    num_d        = num_q;
    last_d       = 1'b0;
    obytes_d     = obytes_q;
    olen_d       = olen_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept && (cmd_i == CMD_EVENT) && len_ok && (count_eff != '0)) begin
          state_d      = S_SCAN;
          idx_d        = '0;
          issued_all_d = 1'b0;
          pend_d       = 1'b0;
          cnt_d        = count_eff;
          ev_bytes_d   = pad_bytes;
          ev_len_d     = event_length_i[1:0];
        end
      end
      S_SCAN: begin
        // Issue one read per cycle until the last rule in use.
        if (!issued_all_q) begin
          rdv_d    = 1'b1;
          rdi_d    = idx_q;
          rdlast_d = (CNT_W'(idx_q) == cnt_q - CNT_W'(1));
          idx_d    = idx_q + IDX_W'(1);
          issued_all_d = rdlast_d;
        end
        // Evaluate the entry read in the previous cycle.
        if (rdv_q && hit) begin
          if (pend_q) begin
            strobe_d = 1'b1;
            num_d    = 4'(pend_idx_q);
            last_d   = 1'b0;
            obytes_d = ev_bytes_q;
            olen_d   = ev_len_q;
          end
          pend_d     = 1'b1;
          pend_idx_d = rdi_q;
        end
        if (rdv_q && rdlast_q) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (pend_q) begin
          strobe_d = 1'b1;
          num_d    = 4'(pend_idx_q);
          last_d   = 1'b1;
          obytes_d = ev_bytes_q;
          olen_d   = ev_len_q;
        end
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rules_in_use_q <= 5'd0;
      issued_all_q   <= 1'b0;
      rdv_q          <= 1'b0;
      rdlast_q       <= 1'b0;
      pend_q         <= 1'b0;
      strobe_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      issued_all_q <= issued_all_d;
      rdv_q        <= rdv_d;
      rdlast_q     <= rdlast_d;
      pend_q       <= pend_d;
      strobe_q     <= strobe_d;
      if (cfg_we_i) begin
        rules_in_use_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    rdi_q      <= rdi_d;
    pend_idx_q <= pend_idx_d;
    cnt_q      <= cnt_d;
    ev_bytes_q <= ev_bytes_d;
    ev_len_q   <= ev_len_d;
    num_q      <= num_d;
    last_q     <= last_d;
    obytes_q   <= obytes_d;
    olen_q     <= olen_d;
  end

  assign out_strobe_o   = strobe_q;
  assign rule_number_o  = num_q;
  assign last_match_o   = last_q;
  assign out_status_o   = obytes_q[7:0];
  assign out_data_one_o = obytes_q[15:8];
  assign out_data_two_o = obytes_q[23:16];
  assign out_length_o   = olen_q;

endmodule
